@@ rtl/calendar_date_advance_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Calendar date advance unit: assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADVANCE_UNIT_MACROS_SVH
`define CALENDAR_DATE_ADVANCE_UNIT_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define CDAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar date advance unit: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define CDAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar date advance unit: assertion failed");
`else
`define CDAU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/cdau_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date advance unit: package
// Field widths, operation and state codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package cdau_pkg;

  // Field widths.
  localparam int YEAR_BITS  = 16;
  localparam int DAY_BITS   = 5;
  localparam int MONTH_BITS = 4;
  localparam int NDAYS_BITS = 16;
  // Working day count holds a stored day plus the full advance count.
  localparam int WORK_BITS  = NDAYS_BITS + 1;

  // Calendar constants.
  localparam int GREG_CYCLE  = 400;
  localparam int CENTURY     = 100;
  localparam int MONTHS      = 12;
  localparam int MONTH_LONG  = 31;
  localparam int MONTH_SHORT = 30;

  // Year residue modulo 400 is found by conditional subtraction of 400 shifted
  // down from the largest multiple that fits in the year width.
  localparam int RED_STEPS = YEAR_BITS - 8;
  localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_COMPARE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WALK,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              red_step;
    logic [STEP_W-1:0] red_shift;
    logic              walk_step;
    logic              emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic walk_done;
  } dp_sts_t;

endpackage

@@ rtl/cdau_req_if.sv @@
// ----------------------------------------------------------------------------
// Calendar date advance unit: request channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface cdau_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic [cdau_pkg::DAY_BITS-1:0]    day;
  logic [cdau_pkg::MONTH_BITS-1:0]  month;
  logic [cdau_pkg::YEAR_BITS-1:0]   year;
  logic [cdau_pkg::NDAYS_BITS-1:0]  n_days;

  modport source (output valid, op, day, month, year, n_days, input ready);
  modport sink   (input valid, op, day, month, year, n_days, output ready);
endinterface

@@ rtl/cdau_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Calendar date advance unit: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface cdau_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cdau_pkg::DAY_BITS-1:0]    cur_day_out;
  logic [cdau_pkg::MONTH_BITS-1:0]  cur_month_out;
  logic [cdau_pkg::YEAR_BITS-1:0]   cur_year_out;
  logic [1:0]                       order;
  logic                             bad_date;
  logic                             year_overflow;

  modport source (output valid, cur_day_out, cur_month_out, cur_year_out, order,
                  bad_date, year_overflow, input ready);
  modport sink   (input valid, cur_day_out, cur_month_out, cur_year_out, order,
                  bad_date, year_overflow, output ready);
endinterface

@@ rtl/cdau_ctl.sv @@
// ----------------------------------------------------------------------------
// Calendar date advance unit: controller
// Sequences accept, year residue reduction, month walk and result hand-off.
// ----------------------------------------------------------------------------
module cdau_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_op,
  output logic                req_ready,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  input  cdau_pkg::dp_sts_t   sts,
  output cdau_pkg::ctl_cmd_t  cmd
);

  cdau_pkg::state_t                state;
  cdau_pkg::state_t                state_next;
  logic [cdau_pkg::STEP_W-1:0]     step;
  logic [cdau_pkg::STEP_W-1:0]     step_next;
  logic                            rsp_valid_next;

  // State, step counter and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdau_pkg::ST_IDLE;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    step_next     = step;
    req_ready     = 1'b0;
    cmd           = '0;
    cmd.red_shift = step;
    unique case (state)
      cdau_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (req_op == cdau_pkg::OP_ADVANCE && !sts.bad) begin
            state_next = cdau_pkg::ST_REDUCE;
            step_next  = cdau_pkg::STEP_W'(cdau_pkg::RED_STEPS - 1);
          end else begin
            state_next = cdau_pkg::ST_EMIT;
          end
        end
      end
      cdau_pkg::ST_REDUCE: begin
        cmd.red_step = 1'b1;
        if (step == '0) begin
          state_next = cdau_pkg::ST_WALK;
        end else begin
          step_next = step - 1'b1;
        end
      end
      cdau_pkg::ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          state_next = cdau_pkg::ST_EMIT;
        end
      end
      cdau_pkg::ST_EMIT: begin
        // Wait here while an earlier result is still held on the output.
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = cdau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdau_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register is full from a hand-off until its beat is taken.
  always_comb begin
    if (cmd.emit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

@@ rtl/cdau_dp.sv @@
// ----------------------------------------------------------------------------
// Calendar date advance unit: datapath
// Stored date, year residue unit, month walk and the output register.
// ----------------------------------------------------------------------------
module cdau_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  cdau_pkg::ctl_cmd_t                 cmd,
  output cdau_pkg::dp_sts_t                  sts,
  input  logic [1:0]                         op,
  input  logic [cdau_pkg::DAY_BITS-1:0]      day,
  input  logic [cdau_pkg::MONTH_BITS-1:0]    month,
  input  logic [cdau_pkg::YEAR_BITS-1:0]     year,
  input  logic [cdau_pkg::NDAYS_BITS-1:0]    n_days,
  output logic [cdau_pkg::DAY_BITS-1:0]      cur_day_out,
  output logic [cdau_pkg::MONTH_BITS-1:0]    cur_month_out,
  output logic [cdau_pkg::YEAR_BITS-1:0]     cur_year_out,
  output logic [1:0]                         order,
  output logic                               bad_date,
  output logic                               year_overflow
);

  localparam int YB = cdau_pkg::YEAR_BITS;
  localparam int WB = cdau_pkg::WORK_BITS;
  localparam logic [YB-1:0] RES_CYCLE = YB'(cdau_pkg::GREG_CYCLE);
  localparam logic [YB-1:0] RES_LAST  = YB'(cdau_pkg::GREG_CYCLE - 1);
  localparam logic [YB-1:0] RES_C1    = YB'(cdau_pkg::CENTURY);
  localparam logic [YB-1:0] RES_C2    = YB'(2 * cdau_pkg::CENTURY);
  localparam logic [YB-1:0] RES_C3    = YB'(3 * cdau_pkg::CENTURY);
  localparam logic [cdau_pkg::MONTH_BITS-1:0] DEC =
    cdau_pkg::MONTH_BITS'(cdau_pkg::MONTHS);

  // Stored date.
  logic [cdau_pkg::DAY_BITS-1:0]    cur_day;
  logic [cdau_pkg::MONTH_BITS-1:0]  cur_month;
  logic [YB-1:0]                    cur_year;
  logic                             bad_flag;

  // Working registers of one operation.
  logic [WB-1:0]                    work_day;
  logic [YB-1:0]                    residue;
  logic [1:0]                       order_q;
  logic                             ovf_q;

  logic                             leap;
  logic [cdau_pkg::DAY_BITS-1:0]    last;
  logic                             walk_done;
  logic [YB-1:0]                    red_sub;
  logic [1:0]                       order_calc;
  logic                             year_max;

  // Length of a month; months outside the calendar are never walked.
  function automatic logic [cdau_pkg::DAY_BITS-1:0] month_days(
    input logic [cdau_pkg::MONTH_BITS-1:0] m,
    input logic                            lp
  );
    logic [cdau_pkg::DAY_BITS-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = cdau_pkg::DAY_BITS'(cdau_pkg::MONTH_SHORT);
      4'd2:                    len = lp ? 5'd29 : 5'd28;
      default:                 len = cdau_pkg::DAY_BITS'(cdau_pkg::MONTH_LONG);
    endcase
    return len;
  endfunction

  // A year divisible by four is a leap year unless it is a century that is
  // not a multiple of four hundred; the residue gives the century test.
  assign leap = (cur_year[1:0] == 2'b00) &&
                (residue != RES_C1) && (residue != RES_C2) && (residue != RES_C3);
  assign last      = month_days(cur_month, leap);
  assign walk_done = (work_day <= WB'(last));
  assign red_sub   = RES_CYCLE << cmd.red_shift;
  assign year_max  = (cur_year == {YB{1'b1}});

  assign sts.bad       = bad_flag;
  assign sts.walk_done = walk_done;

  // Compare the stored date with the request date, year first.
  always_comb begin
    if (cur_year != year) begin
      order_calc = (cur_year < year) ? cdau_pkg::ORD_EARLIER : cdau_pkg::ORD_LATER;
    end else if (cur_month != month) begin
      order_calc = (cur_month < month) ? cdau_pkg::ORD_EARLIER : cdau_pkg::ORD_LATER;
    end else if (cur_day != day) begin
      order_calc = (cur_day < day) ? cdau_pkg::ORD_EARLIER : cdau_pkg::ORD_LATER;
    end else begin
      order_calc = cdau_pkg::ORD_EQUAL;
    end
  end

  // Stored date: load on accept, month and year step during the walk, and
  // the remaining day count written back when the walk ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= cdau_pkg::DAY_BITS'(1);
      cur_month <= cdau_pkg::MONTH_BITS'(1);
      cur_year  <= '0;
      bad_flag  <= 1'b0;
    end else begin
      if (cmd.accept && op == cdau_pkg::OP_LOAD) begin
        cur_day   <= day;
        cur_month <= month;
        cur_year  <= year;
        bad_flag  <= (day == '0) || (month == '0) || (month > DEC);
      end
      if (cmd.walk_step) begin
        if (walk_done) begin
          cur_day <= work_day[cdau_pkg::DAY_BITS-1:0];
        end else if (cur_month < DEC) begin
          cur_month <= cur_month + 1'b1;
        end else begin
          cur_month <= cdau_pkg::MONTH_BITS'(1);
          cur_year  <= cur_year + 1'b1;
        end
      end
    end
  end

  // Working registers and residue unit.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      work_day <= WB'(cur_day) + WB'(n_days);
      residue  <= cur_year;
      ovf_q    <= 1'b0;
      order_q  <= (op == cdau_pkg::OP_COMPARE) ? order_calc : cdau_pkg::ORD_EARLIER;
    end
    if (cmd.red_step && residue >= red_sub) begin
      residue <= residue - red_sub;
    end
    if (cmd.walk_step && !walk_done) begin
      work_day <= work_day - WB'(last);
      if (cur_month >= DEC) begin
        // New year: residue follows the year, and a wrap restarts at zero.
        if (year_max) begin
          residue <= '0;
          ovf_q   <= 1'b1;
        end else if (residue == RES_LAST) begin
          residue <= '0;
        end else begin
          residue <= residue + 1'b1;
        end
      end
    end
  end

  // Output register, loaded when the controller hands off a result.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cur_day_out   <= cur_day;
      cur_month_out <= cur_month;
      cur_year_out  <= cur_year;
      order         <= order_q;
      bad_date      <= bad_flag;
      year_overflow <= ovf_q;
    end
  end

endmodule

@@ rtl/calendar_date_advance_unit.sv @@
// ----------------------------------------------------------------------------
// Calendar date advance unit
// Holds one Gregorian date; loads, advances by a day count, and compares.
//
//   Channel  Dir  Handshake     Beat contents
//   req      in   valid/ready   op, day, month, year, n_days
//   rsp      out  valid/ready   cur_day_out, cur_month_out, cur_year_out,
//                               order, bad_date, year_overflow
//
// Load, compare, no-op and an advance of a flagged date go from accept
// straight to the result hand-off. An advance of a well-formed date first
// runs a residue reduction of the year by conditional subtraction, then
// the month walk at one month per cycle.
// A request is taken only while no operation is in flight; a result that is
// not taken holds the next finished result in its final state.
// Reset is synchronous and restores 1 January of year 0 at once.
// ----------------------------------------------------------------------------
`include "calendar_date_advance_unit_macros.svh"

module calendar_date_advance_unit (
  input  logic        clk,
  input  logic        rst,
  cdau_req_if.sink    req,
  cdau_rsp_if.source  rsp
);

  cdau_pkg::ctl_cmd_t cmd;
  cdau_pkg::dp_sts_t  sts;

  // Sequencer.
  cdau_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Date registers, arithmetic and output register.
  cdau_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (req.op),
    .day           (req.day),
    .month         (req.month),
    .year          (req.year),
    .n_days        (req.n_days),
    .cur_day_out   (rsp.cur_day_out),
    .cur_month_out (rsp.cur_month_out),
    .cur_year_out  (rsp.cur_year_out),
    .order         (rsp.order),
    .bad_date      (rsp.bad_date),
    .year_overflow (rsp.year_overflow)
  );

  // A load with day zero marks the stored date bad.
  `CDAU_ASSERT_NEXT(a_load_day_zero_bad, clk, rst,
                    req.valid && req.ready && req.op == cdau_pkg::OP_LOAD && req.day == '0,
                    sts.bad)
  // No residue or walk step runs while a request can be taken.
  `CDAU_ASSERT_IMPL(a_idle_no_steps, clk, rst, req.ready, !cmd.red_step && !cmd.walk_step)
  // Compare results of equal or later never report a year wrap.
  `CDAU_ASSERT_IMPL(a_order_no_ovf, clk, rst,
                    rsp.valid && rsp.order != cdau_pkg::ORD_EARLIER, !rsp.year_overflow)
  // A wrapped advance only happens from a well-formed date.
  `CDAU_ASSERT_IMPL(a_ovf_not_bad, clk, rst, rsp.valid && rsp.year_overflow, !rsp.bad_date)

endmodule

@@ verif/cdau_date_tracker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date advance unit: date tracker
// Watches the request and response channels and keeps its own copy of the
// stored date. Every accepted request beat queues the result the unit should
// return. Every accepted response beat is compared, field by field, with the
// oldest queued result. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module cdau_date_tracker
  import cdau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  cdau_req_if   req,
  cdau_rsp_if   rsp,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
    logic [1:0]            order;
    logic                  bad;
    logic                  ovf;
  } date_result_t;

  // Tracked copy of the date register.
  logic [DAY_BITS-1:0]   held_day;
  logic [MONTH_BITS-1:0] held_month;
  logic [YEAR_BITS-1:0]  held_year;
  logic                  held_bad;

  date_result_t expected_results[$];
  int           result_count;

  function automatic bit is_leap(logic [YEAR_BITS-1:0] y);
    return (y % 4 == 0) && ((y % CENTURY != 0) || (y % GREG_CYCLE == 0));
  endfunction

  function automatic int unsigned days_in_month(logic [MONTH_BITS-1:0] m,
                                                logic [YEAR_BITS-1:0] y);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return MONTH_SHORT;
      4'd2:                    return is_leap(y) ? 29 : 28;
      default:                 return MONTH_LONG;
    endcase
  endfunction

  // Applies one request to the tracked date and returns the result it causes.
  function automatic date_result_t apply_request(op_t op,
                                                 logic [DAY_BITS-1:0] d_in,
                                                 logic [MONTH_BITS-1:0] m_in,
                                                 logic [YEAR_BITS-1:0] y_in,
                                                 logic [NDAYS_BITS-1:0] n_in);
    date_result_t          r;
    int unsigned           d;
    int unsigned           span;
    logic [MONTH_BITS-1:0] m;
    logic [YEAR_BITS-1:0]  y;
    r = '0;
    r.order = ORD_EARLIER;
    case (op)
      OP_LOAD: begin
        // The date is kept even when it is flagged as bad.
        held_day   = d_in;
        held_month = m_in;
        held_year  = y_in;
        held_bad   = (d_in == 0) || (m_in == 0) || (m_in > MONTHS);
      end
      OP_ADVANCE: begin
        // Walk month by month; a day past the month's end carries forward.
        if (!held_bad) begin
          d    = held_day + n_in;
          m    = held_month;
          y    = held_year;
          span = days_in_month(m, y);
          while (d > span) begin
            d = d - span;
            if (m < MONTHS) begin
              m = m + 1'b1;
            end else begin
              m = 1;
              if (y == '1) begin
                r.ovf = 1'b1;
              end
              y = y + 1'b1;
            end
            span = days_in_month(m, y);
          end
          held_day   = d[DAY_BITS-1:0];
          held_month = m;
          held_year  = y;
        end
      end
      OP_COMPARE: begin
        // Year first, then month, then day decide the order.
        if (held_year != y_in) begin
          r.order = (held_year < y_in) ? ORD_EARLIER : ORD_LATER;
        end else if (held_month != m_in) begin
          r.order = (held_month < m_in) ? ORD_EARLIER : ORD_LATER;
        end else if (held_day != d_in) begin
          r.order = (held_day < d_in) ? ORD_EARLIER : ORD_LATER;
        end else begin
          r.order = ORD_EQUAL;
        end
      end
      default: begin
      end
    endcase
    r.day   = held_day;
    r.month = held_month;
    r.year  = held_year;
    r.bad   = held_bad;
    return r;
  endfunction

  task automatic report_mismatch(input string note);
    fail_count++;
    $display("%0t ns  date tracker: result %0d: %s", $time, result_count, note);
  endtask

  // Compare response beats against the queue, then queue the next request.
  always @(posedge clk) begin : track
    date_result_t got;
    date_result_t want;
    if (rst) begin
      held_day     = 1;
      held_month   = 1;
      held_year    = '0;
      held_bad     = 1'b0;
      fail_count   = 0;
      result_count = 0;
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.day   = rsp.cur_day_out;
        got.month = rsp.cur_month_out;
        got.year  = rsp.cur_year_out;
        got.order = rsp.order;
        got.bad   = rsp.bad_date;
        got.ovf   = rsp.year_overflow;
        if (expected_results.size() == 0) begin
          report_mismatch("response beat with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (got.day !== want.day)
            report_mismatch($sformatf("day %0d, expected %0d", got.day, want.day));
          if (got.month !== want.month)
            report_mismatch($sformatf("month %0d, expected %0d", got.month, want.month));
          if (got.year !== want.year)
            report_mismatch($sformatf("year %0d, expected %0d", got.year, want.year));
          if (got.order !== want.order)
            report_mismatch($sformatf("order %0d, expected %0d", got.order, want.order));
          if (got.bad !== want.bad)
            report_mismatch($sformatf("bad_date %0b, expected %0b", got.bad, want.bad));
          if (got.ovf !== want.ovf)
            report_mismatch($sformatf("year_overflow %0b, expected %0b", got.ovf,
                                      want.ovf));
        end
        result_count++;
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_request(op_t'(req.op), req.day, req.month,
                                                 req.year, req.n_days));
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ verif/calendar_date_advance_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date advance unit: testbench top
// Drives directed and random load, advance, compare and no-op beats into the
// unit with bursty input timing and a stalling response side, and leaves the
// checking to the date tracker. Reports the verdict at the end of the run.
// ----------------------------------------------------------------------------
module calendar_date_advance_unit_tb;
  import cdau_pkg::*;

  localparam int RANDOM_ITEMS  = 250;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_CYCLES  = 3_000_000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   hold_off_go;

  // Sender pacing and the last date loaded, used to aim compare beats.
  int                    issued = 0;
  int                    burst_left = 0;
  logic [DAY_BITS-1:0]   saved_day = 1;
  logic [MONTH_BITS-1:0] saved_month = 1;
  logic [YEAR_BITS-1:0]  saved_year = '0;

  cdau_req_if req_ch ();
  cdau_rsp_if rsp_ch ();

  calendar_date_advance_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cdau_date_tracker date_tracker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response side: stretches of steady, light, heavy or toggling stalls, and
  // one long hold-off on request.
  initial begin : rsp_pacing
    int stretch_left;
    int mode;
    int hold_left;
    bit hold_taken;
    stretch_left = 0;
    mode         = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(60, 8);
        mode         = $urandom_range(3, 0);
      end
      stretch_left--;
      if (hold_off_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(3, 0) != 0);
          2:       rsp_ch.ready <= ($urandom_range(3, 0) == 0);
          default: rsp_ch.ready <= ~rsp_ch.ready;
        endcase
      end
    end
  end

  function automatic logic [YEAR_BITS-1:0] pick_year();
    case ($urandom_range(4, 0))
      0:       return YEAR_BITS'($urandom_range(2100, 1900));
      1:       return YEAR_BITS'($urandom_range(655, 0) * CENTURY);
      2:       return YEAR_BITS'($urandom_range(65535, 65500));
      3:       return YEAR_BITS'($urandom_range(40, 0));
      default: return YEAR_BITS'($urandom());
    endcase
  endfunction

  // Mostly short advances; the full count is slow, so it is kept rare.
  function automatic logic [NDAYS_BITS-1:0] pick_span();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return NDAYS_BITS'($urandom_range(60, 0));
    if (r < 80) return NDAYS_BITS'($urandom_range(800, 0));
    if (r < 92) return NDAYS_BITS'($urandom_range(8000, 0));
    if (r < 97) return NDAYS_BITS'($urandom());
    return ($urandom_range(1, 0) != 0) ? '1 : '0;
  endfunction

  // Offers one beat after the current burst's gap and waits for acceptance.
  // Entered and left at a falling edge.
  task automatic send_request(input op_t op, input logic [DAY_BITS-1:0] day,
                              input logic [MONTH_BITS-1:0] month,
                              input logic [YEAR_BITS-1:0] year,
                              input logic [NDAYS_BITS-1:0] n_days);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap        = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(15, 1);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.op     <= op;
    req_ch.day    <= day;
    req_ch.month  <= month;
    req_ch.year   <= year;
    req_ch.n_days <= n_days;
    req_ch.valid  <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    issued++;
    if (op == OP_LOAD) begin
      saved_day   = day;
      saved_month = month;
      saved_year  = year;
    end
  endtask

  // Holds the input idle until every outstanding result has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // One load, well formed or not, followed by a few operations on that date.
  task automatic run_date_sequence();
    int                    ops;
    int                    r;
    logic [DAY_BITS-1:0]   cd;
    logic [MONTH_BITS-1:0] cm;
    logic [YEAR_BITS-1:0]  cy;
    if ($urandom_range(99, 0) < 85) begin
      send_request(OP_LOAD, DAY_BITS'($urandom_range(31, 1)),
                   MONTH_BITS'($urandom_range(12, 1)), pick_year(), NDAYS_BITS'($urandom()));
    end else begin
      case ($urandom_range(2, 0))
        0:       begin cd = '0; cm = MONTH_BITS'($urandom_range(12, 1)); end
        1:       begin
          cd = DAY_BITS'($urandom());
          cm = ($urandom_range(1, 0) != 0) ? '0 : MONTH_BITS'($urandom_range(15, 13));
        end
        default: begin cd = DAY_BITS'($urandom()); cm = MONTH_BITS'($urandom()); end
      endcase
      send_request(OP_LOAD, cd, cm, pick_year(), NDAYS_BITS'($urandom()));
    end
    ops = $urandom_range(6, 1);
    repeat (ops) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        send_request(OP_ADVANCE, DAY_BITS'($urandom()), MONTH_BITS'($urandom()),
                     YEAR_BITS'($urandom()), pick_span());
      end else if (r < 80) begin
        // Aim near the loaded date so every level of the ordering is exercised.
        cd = saved_day;
        cm = saved_month;
        cy = saved_year;
        case ($urandom_range(5, 0))
          0: ;
          1: cy = ($urandom_range(1, 0) != 0) ? cy + 1'b1 : cy - 1'b1;
          2: cm = ($urandom_range(1, 0) != 0) ? cm + 1'b1 : cm - 1'b1;
          3: cd = ($urandom_range(1, 0) != 0) ? cd + 1'b1 : cd - 1'b1;
          default: begin
            cd = DAY_BITS'($urandom());
            cm = MONTH_BITS'($urandom());
            cy = pick_year();
          end
        endcase
        send_request(OP_COMPARE, cd, cm, cy, NDAYS_BITS'($urandom()));
      end else if (r < 85) begin
        send_request(OP_NOP, DAY_BITS'($urandom()), MONTH_BITS'($urandom()),
                     YEAR_BITS'($urandom()), NDAYS_BITS'($urandom()));
      end else begin
        send_request(op_t'($urandom_range(3, 0)), DAY_BITS'($urandom()),
                     MONTH_BITS'($urandom()), YEAR_BITS'($urandom()),
                     NDAYS_BITS'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    int  directed;
    bit  held;
    bit  drained;
    rst           = 1'b1;
    hold_off_go   = 1'b0;
    held          = 1'b0;
    drained       = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.op     = OP_NOP;
    req_ch.day    = '0;
    req_ch.month  = '0;
    req_ch.year   = '0;
    req_ch.n_days = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset date, compares against it, and a no-op with every bit set.
    send_request(OP_COMPARE, 5'd1, 4'd1, 16'd0, 16'd0);
    send_request(OP_COMPARE, 5'd31, 4'd12, 16'hFFFF, 16'd0);
    send_request(OP_COMPARE, 5'd0, 4'd0, 16'd0, 16'd0);
    send_request(OP_NOP, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
    // Zero advance, then into the leap February of year zero.
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd59);
    // Year wrap from the last day of the largest year.
    send_request(OP_LOAD, 5'd31, 4'd12, 16'hFFFF, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
    // Day past the end of its month, carried by a zero advance.
    send_request(OP_LOAD, 5'd31, 4'd4, 16'd2023, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
    // Century rules for February.
    send_request(OP_LOAD, 5'd28, 4'd2, 16'd1900, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
    send_request(OP_LOAD, 5'd28, 4'd2, 16'd2000, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
    // Bad dates are stored, compared, and never advanced.
    send_request(OP_LOAD, 5'd0, 4'd5, 16'd2000, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd10);
    send_request(OP_COMPARE, 5'd0, 4'd5, 16'd2000, 16'd0);
    send_request(OP_LOAD, 5'd15, 4'd0, 16'd2000, 16'd0);
    send_request(OP_LOAD, 5'd15, 4'd13, 16'd2000, 16'd0);
    send_request(OP_LOAD, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    // Largest advance across the year wrap.
    send_request(OP_LOAD, 5'd1, 4'd1, 16'hFFFF, 16'd0);
    send_request(OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    send_request(OP_NOP, 5'd0, 4'd0, 16'd0, 16'd0);
    directed = issued;
    wait_drained();

    // Random date sequences, with one long response hold-off and one full drain.
    while (issued < directed + RANDOM_ITEMS) begin
      if (!held && issued >= directed + 80) begin
        hold_off_go <= 1'b1;
        held = 1'b1;
      end
      if (!drained && issued >= directed + 160) begin
        wait_drained();
        drained = 1'b1;
      end
      run_date_sequence();
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
